// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// File: sv/lpws_pkg.sv
// ----------------------------------------------------------------------------
// lpws_pkg
// Shared types and constants of the LED pulse width serializer.
// ----------------------------------------------------------------------------
package lpws_pkg;

    localparam int CFG_W       = 16;
    localparam int DATA_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;
    localparam int BIT_IDX_W   = 3;

    localparam logic [DATA_W-1:0]    MSB_MASK     = 8'h80;
    localparam logic [BIT_IDX_W-1:0] LAST_BIT_IDX = 3'd7;

    localparam logic [CFG_W-1:0] ZERO_HIGH_RST = 16'd40;
    localparam logic [CFG_W-1:0] ONE_HIGH_RST  = 16'd80;
    localparam logic [CFG_W-1:0] PERIOD_RST    = 16'd125;
    localparam logic             INVERT_RST    = 1'b0;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_TICK = 1'b1
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_HIGH = 2'd0,
        CFG_ONE_HIGH  = 2'd1,
        CFG_PERIOD    = 2'd2,
        CFG_INVERT    = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        TX_IDLE  = 2'd0,
        TX_SEND  = 2'd1,
        TX_STALL = 2'd2
    } t_tx_state;

    typedef struct packed {
        t_kind             kind;
        logic [DATA_W-1:0] data_byte;
        logic              last_byte;
    } t_req;

    typedef struct packed {
        logic [CFG_W-1:0] zero_high;
        logic [CFG_W-1:0] one_high;
        logic [CFG_W-1:0] period;
        logic             invert;
    } t_cfg;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic room_for_byte;
        logic done_res;
        logic overrun;
        logic underrun;
    } t_res;

endpackage

// File: sv/lpws_if.sv
// ----------------------------------------------------------------------------
// lpws_if
// Request and result channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lpws_in_if import lpws_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              func;
    logic [DATA_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, func, data_byte, last_byte, input ready);
    modport sink   (input valid, func, data_byte, last_byte, output ready);
endinterface

interface lpws_out_if import lpws_pkg::*; ();
    logic valid;
    logic ready;
    logic line_level;
    logic busy_res;
    logic room_for_byte;
    logic done_res;
    logic overrun;
    logic underrun;

    modport source (output valid, line_level, busy_res, room_for_byte, done_res, overrun,
                    underrun, input ready);
    modport sink   (input valid, line_level, busy_res, room_for_byte, done_res, overrun,
                    underrun, output ready);
endinterface

// File: sv/lpws_front.sv
// ----------------------------------------------------------------------------
// lpws_front
// Accepts requests, classifies them as load or tick, and queues them.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpws_front import lpws_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    lpws_in_if.sink i_req,
    output t_req  o_q_req,
    output logic  o_q_valid,
    input  logic  i_q_ready
);

    t_req              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    t_req              w_req;
    logic              w_push;
    logic              w_pop;

    assign i_req.ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign w_push      = i_req.valid && i_req.ready;
    assign o_q_valid   = (r_count != '0);
    assign w_pop       = o_q_valid && i_q_ready;
    assign o_q_req     = r_mem[r_rd_ptr];

    always_comb begin
        w_req.kind      = i_req.func ? KIND_TICK : KIND_LOAD;
        w_req.data_byte = i_req.data_byte;
        w_req.last_byte = i_req.last_byte;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `ASSERT_PROP(a_q_fill, i_clk, i_rst_n, (w_push && !w_pop) |=> (r_count == $past(r_count) + 1'b1), "queue count did not grow on push")
    `ASSERT_NEVER(a_q_over, i_clk, i_rst_n, r_count > QCNT_W'(QUEUE_DEPTH), "queue count beyond depth")

endmodule

// File: sv/lpws_back.sv
// ----------------------------------------------------------------------------
// lpws_back
// Holding register, bit shifter and pulse timer; registers one result per request.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpws_back import lpws_pkg::*; #(
    parameter int TICK_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  t_req i_q_req,
    input  logic i_q_valid,
    output logic o_q_ready,
    output t_res o_res,
    output logic o_res_valid,
    input  logic i_res_ready
);

    localparam int CW = (TICK_BITS > CFG_W) ? TICK_BITS : CFG_W;
    localparam logic [CW-1:0]        CNT_MAX_W = CW'((64'd1 << TICK_BITS) - 64'd1);
    localparam logic [TICK_BITS-1:0] CNT_MAX   = '1;

    function automatic logic [TICK_BITS-1:0] f_clip(input logic [CFG_W-1:0] v);
        logic [CW-1:0] ext;
        ext = CW'(v);
        return (ext > CNT_MAX_W) ? CNT_MAX : ext[TICK_BITS-1:0];
    endfunction

    t_tx_state              r_state, n_state;
    logic [DATA_W-1:0]      r_shift, n_shift;
    logic [BIT_IDX_W-1:0]   r_bit_idx, n_bit_idx;
    logic [TICK_BITS-1:0]   r_tick, n_tick;
    logic                   r_cur_last, n_cur_last;
    logic [DATA_W-1:0]      r_held_byte, n_held_byte;
    logic                   r_held_valid, n_held_valid;
    logic                   r_held_last, n_held_last;
    t_res                   r_res, n_res;
    logic                   r_res_valid;

    logic                   w_go;
    logic                   w_is_tick;
    logic                   w_cur_bit;
    logic [TICK_BITS-1:0]   w_hi;
    logic [TICK_BITS-1:0]   w_per;
    logic [TICK_BITS-1:0]   w_len;
    logic [TICK_BITS-1:0]   w_tick_inc;
    logic                   w_last_bit;
    logic                   w_done;
    logic                   w_bit_end;
    logic                   w_take;
    logic                   w_under;
    logic                   w_ovr;
    logic                   w_next_bit;
    logic [TICK_BITS-1:0]   w_next_hi;

    assign o_q_ready   = !r_res_valid || i_res_ready;
    assign w_go        = i_q_valid && o_q_ready;
    assign w_is_tick   = (i_q_req.kind == KIND_TICK);

    assign w_cur_bit   = |((r_shift << r_bit_idx) & MSB_MASK);
    assign w_hi        = f_clip(w_cur_bit ? i_cfg.one_high : i_cfg.zero_high);
    assign w_per       = f_clip(i_cfg.period);
    assign w_len       = (w_hi > w_per) ? w_hi : w_per;
    assign w_tick_inc  = (r_tick != CNT_MAX) ? r_tick + 1'b1 : r_tick;
    assign w_last_bit  = (r_bit_idx == LAST_BIT_IDX);
    assign w_done      = (r_state == TX_SEND) && w_last_bit && r_cur_last && (w_tick_inc >= w_hi);
    assign w_bit_end   = (r_state == TX_SEND) && !w_done && (w_tick_inc >= w_len);
    assign w_take      = r_held_valid && ((r_state != TX_SEND) || (w_bit_end && w_last_bit));
    assign w_under     = w_bit_end && w_last_bit && !r_held_valid;

    always_comb begin
        n_state = r_state;
        if (w_go && w_is_tick) begin
            unique case (r_state)
                TX_IDLE, TX_STALL: begin
                    if (w_take) begin
                        n_state = TX_SEND;
                    end
                end
                TX_SEND: begin
                    if (w_done) begin
                        n_state = TX_IDLE;
                    end else if (w_under) begin
                        n_state = TX_STALL;
                    end
                end
                default: n_state = TX_IDLE;
            endcase
        end
    end

    always_comb begin
        n_shift      = r_shift;
        n_bit_idx    = r_bit_idx;
        n_tick       = r_tick;
        n_cur_last   = r_cur_last;
        n_held_byte  = r_held_byte;
        n_held_valid = r_held_valid;
        n_held_last  = r_held_last;
        w_ovr        = 1'b0;
        if (w_go) begin
            if (!w_is_tick) begin
                if (r_held_valid) begin
                    w_ovr = 1'b1;
                end else begin
                    n_held_byte  = i_q_req.data_byte;
                    n_held_valid = 1'b1;
                    n_held_last  = i_q_req.last_byte;
                end
            end else begin
                if (r_state == TX_SEND) begin
                    if (w_done) begin
                        n_tick    = '0;
                        n_bit_idx = '0;
                    end else if (w_bit_end) begin
                        n_tick    = '0;
                        n_bit_idx = w_last_bit ? '0 : r_bit_idx + 1'b1;
                    end else begin
                        n_tick = w_tick_inc;
                    end
                end
                if (w_take) begin
                    n_shift      = r_held_byte;
                    n_cur_last   = r_held_last;
                    n_held_valid = 1'b0;
                    n_bit_idx    = '0;
                    n_tick       = '0;
                end
            end
        end
    end

    assign w_next_bit = |((n_shift << n_bit_idx) & MSB_MASK);
    assign w_next_hi  = f_clip(w_next_bit ? i_cfg.one_high : i_cfg.zero_high);

    always_comb begin
        n_res.line_level    = ((n_state == TX_SEND) && (n_tick < w_next_hi)) ^ i_cfg.invert;
        n_res.busy_res      = (n_state != TX_IDLE);
        n_res.room_for_byte = !n_held_valid;
        n_res.done_res      = w_is_tick && w_done;
        n_res.overrun       = w_ovr;
        n_res.underrun      = w_is_tick && w_under;
    end

    always_ff @(posedge i_clk) begin
        r_held_byte <= n_held_byte;
        if (w_go) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= TX_IDLE;
            r_shift      <= '0;
            r_bit_idx    <= '0;
            r_tick       <= '0;
            r_cur_last   <= 1'b0;
            r_held_valid <= 1'b0;
            r_held_last  <= 1'b0;
            r_res_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_shift      <= n_shift;
            r_bit_idx    <= n_bit_idx;
            r_tick       <= n_tick;
            r_cur_last   <= n_cur_last;
            r_held_valid <= n_held_valid;
            r_held_last  <= n_held_last;
            if (w_go) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

    `ASSERT_PROP(a_rest_clear, i_clk, i_rst_n, (r_state != TX_SEND) |-> (r_bit_idx == '0 && r_tick == '0), "bit timer not cleared outside a transmission")
    `ASSERT_PROP(a_ovr_full, i_clk, i_rst_n, (r_res_valid && r_res.overrun) |-> !r_res.room_for_byte, "overrun reported with room in holding register")
    `ASSERT_NEVER(a_done_und, i_clk, i_rst_n, r_res_valid && r_res.done_res && r_res.underrun, "done and underrun on one result")

endmodule

// File: sv/led_pulse_width_serializer_core.sv
// A request is written into the queue, then the back end registers its timer update into the result register.
// Throughput: one request per cycle while neither side stalls; the back end updates the bit timer per tick request.
// Either side may stall; the two-entry queue and result register keep the other side moving.
// Reset (i_rst_n low, synchronous): transmitter idle, holding register empty, queue empty,
// timing registers back to their defaults.
// ----------------------------------------------------------------------------
// led_pulse_width_serializer_core
// One-wire LED data encoder: configuration registers, request front end, pulse back end.
// ----------------------------------------------------------------------------
module led_pulse_width_serializer_core import lpws_pkg::*; #(
    parameter int TICK_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lpws_in_if.sink              i_req,
    lpws_out_if.source           o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg r_cfg;
    t_req w_q_req;
    logic w_q_valid;
    logic w_q_ready;
    t_res w_res;
    logic w_res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_high <= ZERO_HIGH_RST;
            r_cfg.one_high  <= ONE_HIGH_RST;
            r_cfg.period    <= PERIOD_RST;
            r_cfg.invert    <= INVERT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ZERO_HIGH: r_cfg.zero_high <= i_cfg_data;
                CFG_ONE_HIGH:  r_cfg.one_high  <= i_cfg_data;
                CFG_PERIOD:    r_cfg.period    <= i_cfg_data;
                CFG_INVERT:    r_cfg.invert    <= i_cfg_data[0];
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    lpws_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_q_req   (w_q_req),
        .o_q_valid (w_q_valid),
        .i_q_ready (w_q_ready)
    );

    lpws_back #(
        .TICK_BITS (TICK_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_req     (w_q_req),
        .i_q_valid   (w_q_valid),
        .o_q_ready   (w_q_ready),
        .o_res       (w_res),
        .o_res_valid (w_res_valid),
        .i_res_ready (o_res.ready)
    );

    assign o_res.valid         = w_res_valid;
    assign o_res.line_level    = w_res.line_level;
    assign o_res.busy_res      = w_res.busy_res;
    assign o_res.room_for_byte = w_res.room_for_byte;
    assign o_res.done_res      = w_res.done_res;
    assign o_res.overrun       = w_res.overrun;
    assign o_res.underrun      = w_res.underrun;

endmodule
